FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

  localparam int MAX_TERMS    = 8;
  localparam int RESULT_DEPTH = 64;

  localparam int REQ_W      = 2;
  localparam int COEFF_IN_W = 16;
  localparam int POWER_IN_W = 8;
  localparam int PROD_W     = 2 * COEFF_IN_W;
  localparam int COEFF_W    = 38;
  localparam int PSUM_W     = POWER_IN_W + 1;

  localparam int TERM_IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TERM_CNT_W = $clog2(MAX_TERMS + 1);
  localparam int RES_IDX_W  = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int RES_CNT_W  = $clog2(RESULT_DEPTH + 1);
  localparam int MAP_DEPTH  = 2 ** PSUM_W;

  localparam int IN_DATA_W  = ((COEFF_IN_W + POWER_IN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COEFF_W + PSUM_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - COEFF_W - PSUM_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_MULTIPLY    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_RD,
    ST_MUL_MAP,
    ST_MUL_LOOK,
    ST_MUL_ACC,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic clear;
  } term_ctrl_t;

  typedef struct packed {
    logic                 valid;
    logic [RES_IDX_W-1:0] idx;
  } map_entry_t;

  typedef struct packed {
    logic        [PSUM_W-1:0]  power;
    logic signed [COEFF_W-1:0] coeff;
  } result_entry_t;

endpackage

FILE: hw/rtl/sparse_polynomial_multiplier.sv
`timescale 1ns / 1ps
// Sparse polynomial multiplier.
// Input channel s_axis: each item is a request. tuser selects its kind: load a term of the
// first polynomial, load a term of the second, or multiply. tdata carries the term's
// coefficient and power; both are ignored by a multiply. The fourth kind code is ignored.
// Output channel m_axis: one item per product term, in order of first appearance, with
// tlast on the final term of a multiply. A multiply with an empty list emits nothing.
// After a multiply has emitted its terms, both term lists are empty again.
// A multiply walks each term pair through ST_MUL_RD, ST_MUL_MAP and ST_MUL_LOOK, and through
// ST_MUL_ACC too when the pair's power is already known, then emits each product term through
// ST_EMIT_RD and ST_EMIT_LOAD, waiting in ST_EMIT_LOAD while the receiver stalls. Every pair
// reads, modifies and writes back the result table and power map in turn.
// While a multiply runs, s_axis_tready is low. A stalled receiver holds the last product
// term in the output register and the sequencer waits for it to be taken.
// After reset the block sweeps its 512-entry power map clear, one entry a cycle, and
// takes no item until the sweep is done.

`include "assert_macros.svh"

module sparse_polynomial_multiplier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // term_coeff [15:0], term_power [23:16]
  input  logic [spm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type [1:0]
  input  logic [spm_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // prod_coeff [37:0], prod_power [46:38], zero [47]
  output logic [spm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);

  spm_pkg::state_t      state;
  spm_pkg::state_t      state_next;
  spm_pkg::req_t        req;
  spm_pkg::term_ctrl_t  term_ctrl;

  logic in_accept;

  logic signed [spm_pkg::COEFF_IN_W-1:0] first_coeff;
  logic        [spm_pkg::POWER_IN_W-1:0] first_power;
  logic signed [spm_pkg::COEFF_IN_W-1:0] second_coeff;
  logic        [spm_pkg::POWER_IN_W-1:0] second_power;
  logic        [spm_pkg::TERM_CNT_W-1:0] first_count;
  logic        [spm_pkg::TERM_CNT_W-1:0] second_count;

  logic [spm_pkg::TERM_CNT_W-1:0] i_cnt;
  logic [spm_pkg::TERM_CNT_W-1:0] j_cnt;
  logic [spm_pkg::RES_CNT_W-1:0]  k_cnt;
  logic [spm_pkg::RES_CNT_W-1:0]  res_count;
  logic [spm_pkg::PSUM_W-1:0]     clr_addr;

  logic        [spm_pkg::PSUM_W-1:0]    psum;
  logic signed [spm_pkg::PROD_W-1:0]    mul;
  logic signed [spm_pkg::COEFF_W-1:0]   prod;
  logic        [spm_pkg::RES_IDX_W-1:0] acc_idx;

  spm_pkg::map_entry_t    map_mem [spm_pkg::MAP_DEPTH];
  spm_pkg::map_entry_t    map_rd;
  spm_pkg::map_entry_t    map_wr;
  logic [spm_pkg::PSUM_W-1:0] map_waddr;
  logic                   map_we;

  spm_pkg::result_entry_t res_mem [spm_pkg::RESULT_DEPTH];
  spm_pkg::result_entry_t res_rd;
  spm_pkg::result_entry_t res_wr;
  logic [spm_pkg::RES_IDX_W-1:0] res_raddr;
  logic [spm_pkg::RES_IDX_W-1:0] res_waddr;
  logic                   res_we;

  logic empty_lists;
  logic last_pair;
  logic last_emit;
  logic clear_done;
  logic append;
  logic pair_done;
  logic out_free;
  logic out_load;

  assign req           = spm_pkg::req_t'(s_axis_tuser);
  assign s_axis_tready = (state == spm_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  spm_term_store u_terms (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (term_ctrl),
    .wr_coeff     (s_axis_tdata[spm_pkg::COEFF_IN_W-1:0]),
    .wr_power     (s_axis_tdata[spm_pkg::COEFF_IN_W +: spm_pkg::POWER_IN_W]),
    .first_addr   (i_cnt[spm_pkg::TERM_IDX_W-1:0]),
    .second_addr  (j_cnt[spm_pkg::TERM_IDX_W-1:0]),
    .first_coeff  (first_coeff),
    .first_power  (first_power),
    .second_coeff (second_coeff),
    .second_power (second_power),
    .first_count  (first_count),
    .second_count (second_count)
  );

  assign empty_lists = (first_count == '0) || (second_count == '0);
  assign last_pair   = (i_cnt + 1'b1 == first_count) && (j_cnt + 1'b1 == second_count);
  assign last_emit   = (k_cnt + 1'b1 == res_count);
  assign clear_done  = (clr_addr == spm_pkg::PSUM_W'(spm_pkg::MAP_DEPTH - 1));
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign mul         = first_coeff * second_coeff;

  function automatic logic [spm_pkg::PSUM_W-1:0] psum_addr_sel();
    return {1'b0, first_power} + {1'b0, second_power};
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      spm_pkg::ST_CLEAR: begin
        if (clear_done) begin
          state_next = spm_pkg::ST_IDLE;
        end
      end
      spm_pkg::ST_IDLE: begin
        if (in_accept && req == spm_pkg::REQ_MULTIPLY && !empty_lists) begin
          state_next = spm_pkg::ST_MUL_RD;
        end
      end
      spm_pkg::ST_MUL_RD:  state_next = spm_pkg::ST_MUL_MAP;
      spm_pkg::ST_MUL_MAP: state_next = spm_pkg::ST_MUL_LOOK;
      spm_pkg::ST_MUL_LOOK: begin
        if (map_rd.valid) begin
          state_next = spm_pkg::ST_MUL_ACC;
        end else if (last_pair) begin
          state_next = spm_pkg::ST_EMIT_RD;
        end else begin
          state_next = spm_pkg::ST_MUL_RD;
        end
      end
      spm_pkg::ST_MUL_ACC: begin
        state_next = last_pair ? spm_pkg::ST_EMIT_RD : spm_pkg::ST_MUL_RD;
      end
      spm_pkg::ST_EMIT_RD: state_next = spm_pkg::ST_EMIT_LOAD;
      spm_pkg::ST_EMIT_LOAD: begin
        if (out_free) begin
          state_next = last_emit ? spm_pkg::ST_IDLE : spm_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = spm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    term_ctrl.load_first  = in_accept && (req == spm_pkg::REQ_LOAD_FIRST);
    term_ctrl.load_second = in_accept && (req == spm_pkg::REQ_LOAD_SECOND);
    term_ctrl.clear       = 1'b0;
    append    = 1'b0;
    pair_done = 1'b0;
    out_load  = 1'b0;
    map_we    = 1'b0;
    map_waddr = clr_addr;
    map_wr    = '0;
    res_we    = 1'b0;
    res_waddr = res_count[spm_pkg::RES_IDX_W-1:0];
    res_wr    = '{power: psum, coeff: prod};
    res_raddr = k_cnt[spm_pkg::RES_IDX_W-1:0];
    case (state)
      spm_pkg::ST_CLEAR: begin
        map_we = 1'b1;
      end
      spm_pkg::ST_IDLE: begin
        term_ctrl.clear = in_accept && (req == spm_pkg::REQ_MULTIPLY) && empty_lists;
      end
      spm_pkg::ST_MUL_LOOK: begin
        res_raddr = map_rd.idx;
        pair_done = !map_rd.valid;
        append    = !map_rd.valid &&
                    (res_count < spm_pkg::RES_CNT_W'(spm_pkg::RESULT_DEPTH));
        map_we    = append;
        map_waddr = psum;
        map_wr    = '{valid: 1'b1, idx: res_count[spm_pkg::RES_IDX_W-1:0]};
        res_we    = append;
      end
      spm_pkg::ST_MUL_ACC: begin
        pair_done = 1'b1;
        res_we    = 1'b1;
        res_waddr = acc_idx;
        res_wr    = '{power: psum, coeff: res_rd.coeff + prod};
      end
      spm_pkg::ST_EMIT_LOAD: begin
        out_load        = out_free;
        term_ctrl.clear = out_free && last_emit;
        // The map entry of each emitted power is freed for the next multiply.
        map_we          = out_free;
        map_waddr       = res_rd.power;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wr;
    end
    map_rd <= map_mem[psum_addr_sel()];
    if (res_we) begin
      res_mem[res_waddr] <= res_wr;
    end
    res_rd <= res_mem[res_raddr];
  end

  always_ff @(posedge clk) begin
    psum <= psum_addr_sel();
    prod <= spm_pkg::COEFF_W'(mul);
    if (state == spm_pkg::ST_MUL_LOOK) begin
      acc_idx <= map_rd.idx;
    end
    if (out_load) begin
      m_axis_tdata <= {{spm_pkg::OUT_PAD_W{1'b0}}, res_rd.power, res_rd.coeff};
      m_axis_tlast <= last_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spm_pkg::ST_CLEAR;
      clr_addr      <= '0;
      i_cnt         <= '0;
      j_cnt         <= '0;
      k_cnt         <= '0;
      res_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == spm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (append) begin
        res_count <= res_count + 1'b1;
      end
      if (pair_done) begin
        if (j_cnt + 1'b1 == second_count) begin
          j_cnt <= '0;
          i_cnt <= last_pair ? '0 : i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
      if (out_load) begin
        k_cnt <= last_emit ? '0 : k_cnt + 1'b1;
        if (last_emit) begin
          res_count <= '0;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_out_no_overwrite, out_load, !m_axis_tvalid || m_axis_tready,
    "product item overwritten before it was taken")
  `ASSERT_NEXT(a_hit_accumulates, state == spm_pkg::ST_MUL_LOOK && map_rd.valid,
    state == spm_pkg::ST_MUL_ACC, "power map hit did not lead to accumulation")
  `ASSERT_IMPLIES(a_res_count_bound, state != spm_pkg::ST_CLEAR,
    res_count <= spm_pkg::RES_CNT_W'(spm_pkg::RESULT_DEPTH), "result count overflow")
  `ASSERT_NEXT(a_lists_cleared, out_load && last_emit,
    first_count == '0 && second_count == '0 && res_count == '0,
    "lists not cleared after the final product item")

endmodule

FILE: hw/rtl/spm_term_store.sv
`timescale 1ns / 1ps

module spm_term_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  spm_pkg::term_ctrl_t                    ctrl,
  input  logic signed [spm_pkg::COEFF_IN_W-1:0]  wr_coeff,
  input  logic        [spm_pkg::POWER_IN_W-1:0]  wr_power,
  input  logic        [spm_pkg::TERM_IDX_W-1:0]  first_addr,
  input  logic        [spm_pkg::TERM_IDX_W-1:0]  second_addr,
  output logic signed [spm_pkg::COEFF_IN_W-1:0]  first_coeff,
  output logic        [spm_pkg::POWER_IN_W-1:0]  first_power,
  output logic signed [spm_pkg::COEFF_IN_W-1:0]  second_coeff,
  output logic        [spm_pkg::POWER_IN_W-1:0]  second_power,
  output logic        [spm_pkg::TERM_CNT_W-1:0]  first_count,
  output logic        [spm_pkg::TERM_CNT_W-1:0]  second_count
);

  logic signed [spm_pkg::COEFF_IN_W-1:0] first_coeff_mem  [spm_pkg::MAX_TERMS];
  logic        [spm_pkg::POWER_IN_W-1:0] first_power_mem  [spm_pkg::MAX_TERMS];
  logic signed [spm_pkg::COEFF_IN_W-1:0] second_coeff_mem [spm_pkg::MAX_TERMS];
  logic        [spm_pkg::POWER_IN_W-1:0] second_power_mem [spm_pkg::MAX_TERMS];

  logic first_we;
  logic second_we;

  // A term arriving at a full list is dropped.
  assign first_we  = ctrl.load_first &&
                     (first_count < spm_pkg::TERM_CNT_W'(spm_pkg::MAX_TERMS));
  assign second_we = ctrl.load_second &&
                     (second_count < spm_pkg::TERM_CNT_W'(spm_pkg::MAX_TERMS));

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_coeff_mem[first_count[spm_pkg::TERM_IDX_W-1:0]] <= wr_coeff;
      first_power_mem[first_count[spm_pkg::TERM_IDX_W-1:0]] <= wr_power;
    end
    if (second_we) begin
      second_coeff_mem[second_count[spm_pkg::TERM_IDX_W-1:0]] <= wr_coeff;
      second_power_mem[second_count[spm_pkg::TERM_IDX_W-1:0]] <= wr_power;
    end
    first_coeff  <= first_coeff_mem[first_addr];
    first_power  <= first_power_mem[first_addr];
    second_coeff <= second_coeff_mem[second_addr];
    second_power <= second_power_mem[second_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      first_count  <= '0;
      second_count <= '0;
    end else begin
      if (first_we) begin
        first_count <= first_count + 1'b1;
      end
      if (second_we) begin
        second_count <= second_count + 1'b1;
      end
    end
  end

endmodule

FILE: tb/sv/tb_sparse_polynomial_multiplier.sv
`timescale 1ns / 1ps

module tb_sparse_polynomial_multiplier;
  import spm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // The slowest multiply enters 64 new powers and then emits 64 product terms.
  localparam int LATENCY_CYCLES = 400;
  localparam int REPORT_LIMIT = 40;

  typedef struct {
    logic signed [COEFF_W-1:0] coeff;
    logic [PSUM_W-1:0]         power;
    logic                      is_last;
  } prod_term_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  logic signed [COEFF_IN_W-1:0] first_coeff [MAX_TERMS];
  logic [POWER_IN_W-1:0]        first_power [MAX_TERMS];
  int                           first_len = 0;
  logic signed [COEFF_IN_W-1:0] second_coeff [MAX_TERMS];
  logic [POWER_IN_W-1:0]        second_power [MAX_TERMS];
  int                           second_len = 0;
  prod_term_t                   pending_terms [$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int multiplies_sent = 0;
  int terms_checked = 0;

  sparse_polynomial_multiplier u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run timed out with %0d product terms still pending.", pending_terms.size());
    $display("tb_sparse_polynomial_multiplier NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Updates the term lists and, on a multiply, queues the product terms it must produce.
  task automatic record_request(input logic [REQ_W-1:0] req,
                                input logic signed [COEFF_IN_W-1:0] coeff,
                                input logic [POWER_IN_W-1:0] power);
    logic signed [COEFF_W-1:0] acc_coeff [RESULT_DEPTH];
    logic [PSUM_W-1:0]         acc_power [RESULT_DEPTH];
    logic signed [COEFF_W-1:0] prod;
    logic [PSUM_W-1:0]         psum;
    prod_term_t                term;
    int                        n_acc;
    int                        k;
    n_acc = 0;
    case (req)
      REQ_LOAD_FIRST: begin
        if (first_len < MAX_TERMS) begin
          first_coeff[first_len] = coeff;
          first_power[first_len] = power;
          first_len++;
        end
      end
      REQ_LOAD_SECOND: begin
        if (second_len < MAX_TERMS) begin
          second_coeff[second_len] = coeff;
          second_power[second_len] = power;
          second_len++;
        end
      end
      REQ_MULTIPLY: begin
        multiplies_sent++;
        for (int i = 0; i < first_len; i++) begin
          for (int j = 0; j < second_len; j++) begin
            psum = first_power[i] + second_power[j];
            prod = first_coeff[i] * second_coeff[j];
            k = 0;
            while (k < n_acc && acc_power[k] != psum) k++;
            if (k < n_acc) begin
              acc_coeff[k] = acc_coeff[k] + prod;
            end else if (n_acc < RESULT_DEPTH) begin
              acc_power[n_acc] = psum;
              acc_coeff[n_acc] = prod;
              n_acc++;
            end
          end
        end
        for (k = 0; k < n_acc; k++) begin
          term.coeff = acc_coeff[k];
          term.power = acc_power[k];
          term.is_last = (k == n_acc - 1);
          pending_terms.push_back(term);
        end
        first_len = 0;
        second_len = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [COEFF_IN_W-1:0] coeff,
                           input logic [POWER_IN_W-1:0] power);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {power, coeff};
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    record_request(req, coeff, power);
  endtask

  task automatic sender_rest();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_products();
    sender_rest();
    while (pending_terms.size() != 0) @(posedge clk);
  endtask

  task automatic check_product_term(input logic [OUT_DATA_W-1:0] data, input logic is_last);
    prod_term_t want;
    logic signed [COEFF_W-1:0] got_coeff;
    logic [PSUM_W-1:0]         got_power;
    got_coeff = data[COEFF_W-1:0];
    got_power = data[COEFF_W +: PSUM_W];
    if (pending_terms.size() == 0) begin
      report_mismatch($sformatf("unexpected product term coeff %0d power %0d",
                                got_coeff, got_power));
    end else begin
      want = pending_terms.pop_front();
      terms_checked++;
      if (got_coeff !== want.coeff) begin
        report_mismatch($sformatf("coeff %0d, expected %0d (power %0d)",
                                  got_coeff, want.coeff, want.power));
      end
      if (got_power !== want.power) begin
        report_mismatch($sformatf("power %0d, expected %0d", got_power, want.power));
      end
      if (is_last !== want.is_last) begin
        report_mismatch($sformatf("tlast %b, expected %b (power %0d)",
                                  is_last, want.is_last, want.power));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      check_product_term(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic logic [COEFF_IN_W-1:0] pick_coeff();
    case ($urandom_range(11))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return 0;
    if (roll == 1) return MAX_TERMS + $urandom_range(2);
    return $urandom_range(MAX_TERMS, 1);
  endfunction

  task automatic test_empty_products();
    send_item(REQ_LOAD_FIRST, 16'd1234, 8'd7);
    send_item(REQ_MULTIPLY, 16'($urandom), 8'($urandom));
    // The lists were cleared, so only the one pair below may appear.
    send_item(REQ_LOAD_FIRST, 16'h8000, 8'hff);
    send_item(REQ_UNUSED, 16'($urandom), 8'($urandom));
    send_item(REQ_LOAD_SECOND, 16'h8000, 8'hff);
    send_item(REQ_MULTIPLY, 16'h0000, 8'h00);
    wait_for_products();
  endtask

  task automatic test_extreme_terms();
    // The two products at power 128 cancel to a zero coefficient.
    send_item(REQ_LOAD_FIRST, 16'h7fff, 8'd0);
    send_item(REQ_LOAD_FIRST, 16'hffff, 8'd128);
    send_item(REQ_LOAD_SECOND, 16'h7fff, 8'd0);
    send_item(REQ_LOAD_SECOND, 16'h0001, 8'd128);
    send_item(REQ_MULTIPLY, 16'hffff, 8'hff);
    wait_for_products();
  endtask

  task automatic test_list_capacity();
    // The ninth term on each side is dropped; the rest sum to the largest coefficient.
    for (int i = 0; i <= MAX_TERMS; i++) send_item(REQ_LOAD_FIRST, 16'h8000, 8'd0);
    for (int i = 0; i <= MAX_TERMS; i++) send_item(REQ_LOAD_SECOND, 16'h8000, 8'd0);
    send_item(REQ_MULTIPLY, 16'($urandom), 8'($urandom));
    wait_for_products();
  endtask

  task automatic test_output_backpressure();
    int base_first;
    int base_second;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = 600;
    for (int rep = 0; rep < 2; rep++) begin
      base_first = $urandom_range(255 - (MAX_TERMS - 1));
      base_second = $urandom_range(255 - MAX_TERMS * (MAX_TERMS - 1));
      for (int i = 0; i < MAX_TERMS; i++) begin
        send_item(REQ_LOAD_FIRST, pick_coeff(), 8'(base_first + i));
      end
      for (int j = 0; j < MAX_TERMS; j++) begin
        send_item(REQ_LOAD_SECOND, pick_coeff(), 8'(base_second + MAX_TERMS * j));
      end
      send_item(REQ_MULTIPLY, 16'($urandom), 8'($urandom));
    end
    wait_for_products();
  endtask

  task automatic test_random_polynomials(input int idle_pct, input int stall_pct,
                                         input int n_items);
    int sent;
    int n_first;
    int n_second;
    bit narrow;
    logic [POWER_IN_W-1:0] power;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      n_first = pick_length();
      n_second = pick_length();
      narrow = ($urandom_range(2) != 0);
      while (n_first > 0 || n_second > 0) begin
        if ($urandom_range(19) == 0) begin
          send_item(REQ_UNUSED, 16'($urandom), 8'($urandom));
        end
        power = narrow ? 8'($urandom_range(7)) : 8'($urandom);
        if ($urandom_range(15) == 0) power = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
        if (n_first > 0 && (n_second == 0 || $urandom_range(1) != 0)) begin
          send_item(REQ_LOAD_FIRST, pick_coeff(), power);
          n_first--;
        end else begin
          send_item(REQ_LOAD_SECOND, pick_coeff(), power);
          n_second--;
        end
        sent++;
      end
      send_item(REQ_MULTIPLY, 16'($urandom), 8'($urandom));
      sent++;
    end
    wait_for_products();
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= REQ_LOAD_FIRST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_products();
    test_extreme_terms();
    test_list_capacity();
    test_output_backpressure();
    test_random_polynomials(0, 0, 70);
    test_random_polynomials(55, 0, 70);
    test_random_polynomials(0, 55, 70);
    test_random_polynomials(18, 18, 70);

    sender_rest();
    wait_for_products();
    repeat (LATENCY_CYCLES) @(posedge clk);

    $display("Covered %0d requests including %0d multiplies and %0d checked product terms,",
             requests_sent, multiplies_sent, terms_checked);
    $display("across empty, extreme, overfull, held-off and randomly idled sequences.");
    if (mismatch_count == 0) begin
      $display("tb_sparse_polynomial_multiplier OK");
    end else begin
      $display("%0d mismatches found.", mismatch_count);
      $display("tb_sparse_polynomial_multiplier NOT OK");
    end
    $finish;
  end

endmodule
